[sv/dapwr_pkg.sv]
// Shared types and constants of the debounced auxiliary power sequencer.
// Used by every module of the block; depends on nothing.

package dapwr_pkg;

    // Number of pin lanes carried by one request, and how many of them are built.
    localparam int NUM_PINS   = 16;
    localparam int NUM_INPUTS = 16;

    // Debounce counter.
    localparam int          CNT_W     = 4;
    localparam logic [3:0]  COUNT_MAX = 4'd15;

    // Power modes.
    localparam logic [1:0] MODE_OFF  = 2'd0;
    localparam logic [1:0] MODE_ON   = 2'd1;
    localparam logic [1:0] MODE_AUTO = 2'd2;

    // Configuration register indexes.
    localparam int         CFG_ADDR_W       = 3;
    localparam logic [2:0] CFG_AUX_MODE     = 3'd0;
    localparam logic [2:0] CFG_ENABLE_MASK  = 3'd1;
    localparam logic [2:0] CFG_INVERT_MASK  = 3'd2;
    localparam logic [2:0] CFG_WAKE_MASK    = 3'd3;
    localparam logic [2:0] CFG_DEB_LIMIT    = 3'd4;
    localparam logic [2:0] CFG_OFF_DELAY    = 3'd5;
    localparam logic [2:0] CFG_HARD_DELAY   = 3'd6;

    // Reset values of the configuration registers.
    localparam logic [1:0]  RST_AUX_MODE   = MODE_AUTO;
    localparam logic [3:0]  RST_DEB_LIMIT  = 4'd10;
    localparam logic [31:0] RST_OFF_DELAY  = 32'd3600000;
    localparam logic [31:0] RST_HARD_DELAY = 32'd300000;

    // Millisecond to second conversion: q = (x * DIV_RECIP) >> DIV_SHIFT.
    // DIV_RECIP is ceil(2^41 / 1000); the rounding error of 448 keeps the
    // quotient exact for every x below 2^31.
    localparam int          LEFT_W    = 31;
    localparam int          PROD_W    = 63;
    localparam int          DIV_SHIFT = 41;
    localparam logic [31:0] DIV_RECIP = 32'd2199023256;
    localparam int          SECS_W    = 23;

    // Configuration seen by the sequencer.
    typedef struct packed {
        logic [1:0]  aux_mode;
        logic [15:0] wake_mask;
        logic [31:0] off_delay_ms;
        logic [31:0] hard_delay_ms;
    } seq_cfg_t;

    // Sequencer status handed to the output stage.
    typedef struct packed {
        logic              secs_ok;
        logic [LEFT_W-1:0] left_ms;
    } seq_stat_t;

    // A deadline is reached when (now - deadline) is zero or positive as a
    // signed 32-bit value. The argument is deadline - now.
    function automatic logic time_reached(input logic [31:0] diff);
        time_reached = (diff == 32'd0) || (diff[31] && (diff[30:0] != 31'd0));
    endfunction

endpackage

[sv/dapwr_lane.sv]
// One debounce lane: optional inversion, a saturating bounce counter and
// the committed level of one pin. Depends on dapwr_pkg.

module dapwr_lane (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    advance,
    input  logic                    pin,
    input  logic                    enable,
    input  logic                    invert,
    input  logic [dapwr_pkg::CNT_W-1:0] limit,
    output logic                    level,
    output logic                    level_next
);
    import dapwr_pkg::*;

    logic             level_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [CNT_W-1:0] cnt_inc;
    logic             val;

    // A contrary reading counts up to saturation, a matching one clears; disabled lanes hold the count, commit zero.
    always_comb
    begin
        val     = pin ^ invert;
        cnt_inc = (cnt_reg == COUNT_MAX) ? cnt_reg : cnt_reg + 1'b1;
        if (!enable)
        begin
            cnt_next   = cnt_reg;
            level_next = 1'b0;
        end
        else
        begin
            cnt_next   = (level_reg != val) ? cnt_inc : '0;
            level_next = (cnt_next > limit) ? val : level_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else if (advance)
        begin
            level_reg <= level_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign level = level_reg;

endmodule

[sv/dapwr_ctrl.sv]
// Merging stage and power sequencer: combines the lane levels into the wake
// condition and runs the off delay and hard cutoff. Depends on dapwr_pkg.

module dapwr_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            advance,
    input  logic [dapwr_pkg::NUM_PINS-1:0]  levels_next,
    input  logic [31:0]                     now_ms,
    input  dapwr_pkg::seq_cfg_t             cfg,
    output logic                            power_on,
    output logic                            request_line,
    output logic                            soft_active,
    output dapwr_pkg::seq_stat_t            stat
);
    import dapwr_pkg::*;

    logic        pw_reg, pw_next;
    logic        rq_reg, rq_next;
    logic        ss_reg, ss_next;
    logic        ws_reg, ws_next;
    logic [31:0] sd_reg, sd_next;
    logic [31:0] hd_reg, hd_next;

    logic        wake_any;
    logic        fired;
    logic        running;
    logic [31:0] soft_left;
    logic [31:0] hard_left;

    // Next state of the sequencer for the request being accepted.
    always_comb
    begin
        pw_next   = pw_reg;
        rq_next   = rq_reg;
        ss_next   = ss_reg;
        ws_next   = ws_reg;
        sd_next   = sd_reg;
        hd_next   = hd_reg;
        fired     = 1'b0;
        running   = 1'b0;
        wake_any  = |(levels_next & cfg.wake_mask);
        // On the tick the wake inputs fall the new deadline is exactly the delay away.
        soft_left = (ws_reg && !wake_any) ? cfg.off_delay_ms : sd_reg - now_ms;

        unique case (cfg.aux_mode)
            MODE_OFF:
            begin
                pw_next = 1'b0;
                rq_next = 1'b1;
                ss_next = 1'b0;
            end
            MODE_ON:
            begin
                pw_next = 1'b1;
                rq_next = 1'b0;
                ss_next = 1'b0;
            end
            MODE_AUTO:
            begin
                if (wake_any)
                begin
                    ws_next = 1'b1;
                    pw_next = 1'b1;
                    rq_next = 1'b0;
                    ss_next = 1'b0;
                end
                else if (ws_reg)
                begin
                    sd_next = now_ms + cfg.off_delay_ms;
                    ws_next = 1'b0;
                end
                // Off countdown runs while powered, with no wake pending and not yet in soft shutdown.
                if (!ws_next && pw_next && !ss_next)
                begin
                    running = 1'b1;
                    if (time_reached(soft_left))
                    begin
                        rq_next = 1'b1;
                        hd_next = now_ms + cfg.hard_delay_ms;
                        ss_next = 1'b1;
                        fired   = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase

        // Pending hard cutoff is checked in every mode; OFF and ON clear soft shutdown, so it cannot fire there.
        hard_left = fired ? cfg.hard_delay_ms : hd_reg - now_ms;
        if (ss_next && time_reached(hard_left))
        begin
            pw_next = 1'b0;
            rq_next = 1'b1;
            ss_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pw_reg <= 1'b0;
            rq_reg <= 1'b0;
            ss_reg <= 1'b0;
            ws_reg <= 1'b0;
            sd_reg <= '0;
            hd_reg <= '0;
        end
        else if (advance)
        begin
            pw_reg <= pw_next;
            rq_reg <= rq_next;
            ss_reg <= ss_next;
            ws_reg <= ws_next;
            sd_reg <= sd_next;
            hd_reg <= hd_next;
        end
    end

    // Remaining time, kept for the seconds conversion of the next stage.
    logic              secs_ok_reg;
    logic [LEFT_W-1:0] left_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            secs_ok_reg <= running && !soft_left[31];
            left_reg    <= soft_left[LEFT_W-1:0];
        end
    end

    assign power_on      = pw_reg;
    assign request_line  = rq_reg;
    assign soft_active   = ss_reg;
    assign stat.secs_ok  = secs_ok_reg;
    assign stat.left_ms  = left_reg;

`ifndef SYNTHESIS
    // Soft shutdown is only entered with power on and the request raised.
    a_soft_implies_req: assert property (@(posedge clk) disable iff (!rst_n)
        ss_reg |-> (pw_reg && rq_reg))
        else $error("soft shutdown without power and request");

    // A running off countdown never coexists with a pending wake.
    a_countdown_no_wake: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && running) |=> !ws_reg)
        else $error("countdown ran while wake was pending");
`endif

endmodule

[sv/dapwr_secdiv.sv]
// Output-stage seconds conversion: remaining milliseconds times a reciprocal
// of 1000, registered, then shifted. Depends on dapwr_pkg.

module dapwr_secdiv (
    input  logic                            clk,
    input  logic                            advance,
    input  dapwr_pkg::seq_stat_t            stat,
    output logic [dapwr_pkg::SECS_W-1:0]    secs
);
    import dapwr_pkg::*;

    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;

    // A negative or idle countdown reads as zero seconds.
    always_comb
    begin
        prod_next = stat.secs_ok ? PROD_W'(stat.left_ms) * PROD_W'(DIV_RECIP) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_reg <= prod_next;
        end
    end

    assign secs = SECS_W'(prod_reg[PROD_W-1:DIV_SHIFT]);

endmodule

[sv/debounced_aux_power_sequencer.sv]
// Debounced auxiliary power sequencer. One request per clock is accepted
// while s_tready is high (a pin sample and the millisecond time) and each
// yields one result: the first stage updates the 16 debounce lanes and the
// power sequencer, the second holds the product of the seconds conversion
// multiplier and is the output register. A stalled result stalls the two
// stages; s_tready follows m_tready combinationally when both are full.
// The configuration port takes a write every cycle (cfg_ready is always
// high); registers should be written only while no request is in flight.
// Depends on dapwr_pkg, dapwr_lane, dapwr_ctrl and dapwr_secdiv.

module debounced_aux_power_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    // Input request: [15:0] pin_levels, [47:16] now_ms.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,
    // Result: [0] aux_power_on, [1] shutdown_request, [2] soft_shutdown_active,
    // [18:3] input_states, [41:19] seconds_until_off, [47:42] zero.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,
    // Configuration writes.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dapwr_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [31:0]                       cfg_wdata
);
    import dapwr_pkg::*;

    // Configuration registers.
    logic [1:0]       aux_mode_reg;
    logic [15:0]      enable_reg;
    logic [15:0]      invert_reg;
    logic [15:0]      wake_reg;
    logic [CNT_W-1:0] limit_reg;
    logic [31:0]      off_delay_reg;
    logic [31:0]      hard_delay_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aux_mode_reg   <= RST_AUX_MODE;
            enable_reg     <= '0;
            invert_reg     <= '0;
            wake_reg       <= '0;
            limit_reg      <= RST_DEB_LIMIT;
            off_delay_reg  <= RST_OFF_DELAY;
            hard_delay_reg <= RST_HARD_DELAY;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_addr)
                CFG_AUX_MODE:    aux_mode_reg   <= cfg_wdata[1:0];
                CFG_ENABLE_MASK: enable_reg     <= cfg_wdata[15:0];
                CFG_INVERT_MASK: invert_reg     <= cfg_wdata[15:0];
                CFG_WAKE_MASK:   wake_reg       <= cfg_wdata[15:0];
                CFG_DEB_LIMIT:   limit_reg      <= cfg_wdata[CNT_W-1:0];
                CFG_OFF_DELAY:   off_delay_reg  <= cfg_wdata;
                CFG_HARD_DELAY:  hard_delay_reg <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    // Pipeline flow control: a stage moves when the one after it can take it.
    logic a_valid_reg;
    logic b_valid_reg;
    logic en_a;
    logic en_b;
    logic accept;

    assign en_b     = !b_valid_reg || m_tready;
    assign en_a     = !a_valid_reg || en_b;
    assign s_tready = en_a;
    assign accept   = s_tvalid && en_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (en_a)
            begin
                a_valid_reg <= s_tvalid;
            end
            if (en_b)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    // Debounce lanes.
    logic [NUM_PINS-1:0] levels;
    logic [NUM_PINS-1:0] levels_next;
    logic [15:0]         pins;
    logic [31:0]         now_ms;

    assign pins   = s_tdata[15:0];
    assign now_ms = s_tdata[47:16];

    for (genvar i = 0; i < NUM_PINS; i++)
    begin : g_lane
        if (i < NUM_INPUTS)
        begin : g_used
            dapwr_lane u_lane (
                .clk        (clk),
                .rst_n      (rst_n),
                .advance    (accept),
                .pin        (pins[i]),
                .enable     (enable_reg[i]),
                .invert     (invert_reg[i]),
                .limit      (limit_reg),
                .level      (levels[i]),
                .level_next (levels_next[i])
            );
        end
        else
        begin : g_unused
            assign levels[i]      = 1'b0;
            assign levels_next[i] = 1'b0;
        end
    end

    // Power sequencer.
    seq_cfg_t  seq_cfg;
    seq_stat_t seq_stat;
    logic      power_on;
    logic      request_line;
    logic      soft_active;

    assign seq_cfg.aux_mode      = aux_mode_reg;
    assign seq_cfg.wake_mask     = wake_reg;
    assign seq_cfg.off_delay_ms  = off_delay_reg;
    assign seq_cfg.hard_delay_ms = hard_delay_reg;

    dapwr_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (accept),
        .levels_next  (levels_next),
        .now_ms       (now_ms),
        .cfg          (seq_cfg),
        .power_on     (power_on),
        .request_line (request_line),
        .soft_active  (soft_active),
        .stat         (seq_stat)
    );

    // Output register.
    logic              out_pw_reg;
    logic              out_rq_reg;
    logic              out_ss_reg;
    logic [15:0]       out_levels_reg;
    logic [SECS_W-1:0] secs;

    always_ff @(posedge clk)
    begin
        if (en_b)
        begin
            out_pw_reg     <= power_on;
            out_rq_reg     <= request_line;
            out_ss_reg     <= soft_active;
            out_levels_reg <= levels;
        end
    end

    dapwr_secdiv u_secdiv (
        .clk     (clk),
        .advance (en_b),
        .stat    (seq_stat),
        .secs    (secs)
    );

    assign m_tvalid = b_valid_reg;
    assign m_tdata  = {6'b0, secs, out_levels_reg, out_ss_reg, out_rq_reg, out_pw_reg};

`ifndef SYNTHESIS
    // An accepted request always occupies the first stage next cycle.
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> a_valid_reg)
        else $error("accepted request lost in first stage");

    // Disabled inputs are committed as zero.
    a_disabled_zero: assert property (@(posedge clk) disable iff (!rst_n)
        $past(accept) |-> ((levels & ~$past(enable_reg)) == '0))
        else $error("disabled input committed high");

    // A nonzero countdown is only reported while powered and not in soft shutdown.
    a_secs_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (secs != '0)) |-> (out_pw_reg && !out_ss_reg))
        else $error("countdown reported in wrong power state");
`endif

endmodule
